[rtl/core/omx_pkg.sv]
// Package for the three-wheel omni drive mixer: payload structs, state and
// direction enums, fixed-point widths and constants. No dependencies.
`timescale 1ns / 1ps

package omx_pkg;

   localparam int NUM_WHEELS = 3;
   localparam int VEL_W      = 16;
   localparam int DUTY_W     = 11;

   // Wheel speeds in units of 2^-29: the input Q13 value times 2^16.
   localparam int SPD_W      = 34;
   localparam int MAG_W      = SPD_W - 1;
   localparam int SHIFT_HALF = 15;
   localparam int SHIFT_ONE  = 16;
   localparam logic signed [17:0] INV_SIN60 = 18'sd75674;
   localparam logic [MAG_W-1:0]   UNIT_ONE  = MAG_W'(64'd1 << 29);

   // Percent quotient, 0..100, built one bit per step.
   localparam int PCT_W  = 7;
   localparam int STEP_W = $clog2(PCT_W);
   localparam int REM_W  = MAG_W + PCT_W;
   localparam int DSH_W  = MAG_W + PCT_W - 1;

   // Duty mapping.
   localparam int DUTY_OFF   = 1024;
   localparam int OFF_W      = $clog2(DUTY_OFF + 1);
   localparam int DIFF_MAG_W = (OFF_W > DUTY_W) ? OFF_W : DUTY_W;
   localparam int PROD_W     = DIFF_MAG_W + PCT_W;
   localparam int QD_W       = PROD_W - 6;
   localparam int RECIP_SHIFT = 30;
   localparam int RECIP_MUL_I = ((1 << RECIP_SHIFT) + 99) / 100;
   localparam int RECIP_W     = $clog2(RECIP_MUL_I + 1);
   localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(RECIP_MUL_I);
   localparam int RP_W        = RECIP_SHIFT + QD_W;
   localparam int SUM_W       = ((OFF_W > QD_W) ? OFF_W : QD_W) + 1;
   localparam logic [DIFF_MAG_W-1:0] OFF_DM  = DIFF_MAG_W'(DUTY_OFF);
   localparam logic [SUM_W-1:0]      OFF_SUM = SUM_W'(DUTY_OFF);
   localparam logic [DUTY_W-1:0]     OFF_OUT = DUTY_W'(DUTY_OFF);

   // Register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL0_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL1_MIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL2_MIN = 2'd2;

   typedef enum logic [1:0] {
      DIR_STOP,
      DIR_POS,
      DIR_NEG
   } omx_dir_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_SCALE,
      BK_RECIP,
      BK_DUTY,
      BK_EMIT
   } omx_back_state_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic signed [VEL_W-1:0] vel_rot;
   } omx_req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] wheel0_duty_a;
      logic [DUTY_W-1:0] wheel0_duty_b;
      logic [DUTY_W-1:0] wheel1_duty_a;
      logic [DUTY_W-1:0] wheel1_duty_b;
      logic [DUTY_W-1:0] wheel2_duty_a;
      logic [DUTY_W-1:0] wheel2_duty_b;
   } omx_rsp_type;

   typedef struct packed {
      logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;
      omx_dir_type [NUM_WHEELS-1:0]     dir;
      logic [MAG_W-1:0]                 divisor;
   } omx_cmd_type;

   typedef struct packed {
      logic [NUM_WHEELS-1:0][DUTY_W-1:0] min_duty;
   } omx_mins_type;

endpackage

[rtl/core/omx_queue.sv]
// Small first-in first-out queue in flops, push/full and pop/empty sides.
// Generic width and depth; no package dependency.
`timescale 1ns / 1ps

module omx_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/core/omx_front.sv]
// Front end of the omni mixer: four-stage pipeline that mixes a velocity
// command into signed wheel speeds, magnitudes, directions and divisor. Uses omx_pkg.
`timescale 1ns / 1ps

module omx_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  omx_pkg::omx_req_type req_data,
   input  logic                 cmd_full,
   output logic                 cmd_push,
   output omx_pkg::omx_cmd_type cmd_data
);
   import omx_pkg::*;

   logic [3:0] vld_ff;
   logic       advance;

   logic signed [SPD_W-1:0] xs_ff, xs_in;
   logic signed [VEL_W-1:0] y_ff, w_ff;
   logic signed [SPD_W-1:0] spd_ff [NUM_WHEELS];
   logic signed [SPD_W-1:0] spd_in [NUM_WHEELS];
   logic signed [SPD_W-1:0] yh, yf, ws;
   logic [MAG_W-1:0]        mag_ff [NUM_WHEELS];
   logic [MAG_W-1:0]        mag_in [NUM_WHEELS];
   omx_dir_type             dir_ff [NUM_WHEELS];
   omx_dir_type             dir_in [NUM_WHEELS];
   omx_cmd_type             cmd_ff, cmd_in;

   // The whole pipe moves as one; hold everything while the last stage waits.
   assign advance  = !vld_ff[3] || !cmd_full;
   assign req_full = !advance;
   assign cmd_push = vld_ff[3] && !cmd_full;
   assign cmd_data = cmd_ff;

   assign xs_in = req_data.vel_x * INV_SIN60;

   always_comb begin
      yh = SPD_W'(y_ff) <<< SHIFT_HALF;
      yf = SPD_W'(y_ff) <<< SHIFT_ONE;
      ws = SPD_W'(w_ff) <<< SHIFT_ONE;
      spd_in[0] = -xs_ff - yh - ws;
      spd_in[1] = yf - ws;
      spd_in[2] = xs_ff - yh - ws;
   end

   always_comb begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
         if (spd_ff[i][SPD_W-1]) begin
            mag_in[i] = MAG_W'(-spd_ff[i]);
            dir_in[i] = DIR_NEG;
         end else begin
            mag_in[i] = MAG_W'(spd_ff[i]);
            dir_in[i] = (spd_ff[i] == '0) ? DIR_STOP : DIR_POS;
         end
      end
   end

   // Divisor is the largest magnitude, never below one.
   always_comb begin
      cmd_in.divisor = UNIT_ONE;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         cmd_in.mag[i] = mag_ff[i];
         cmd_in.dir[i] = dir_ff[i];
         if (mag_ff[i] > cmd_in.divisor) begin
            cmd_in.divisor = mag_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[2:0], req_push};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         xs_ff  <= xs_in;
         y_ff   <= req_data.vel_y;
         w_ff   <= req_data.vel_rot;
         spd_ff <= spd_in;
         mag_ff <= mag_in;
         dir_ff <= dir_in;
         cmd_ff <= cmd_in;
      end
   end

endmodule

[rtl/core/omx_back.sv]
// Back end of the omni mixer: three wheel lanes that divide to a percent one
// bit per cycle, then scale to duty and route by direction. Uses omx_pkg.
`timescale 1ns / 1ps

module omx_back (
   input  logic                  clock,
   input  logic                  reset,
   input  omx_pkg::omx_mins_type mins,
   input  logic                  cmd_empty,
   input  omx_pkg::omx_cmd_type  cmd_data,
   output logic                  cmd_pop,
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output omx_pkg::omx_rsp_type  rsp_data
);
   import omx_pkg::*;

   omx_back_state_type state_ff, state_in;
   logic               load;

   logic [STEP_W-1:0]     step_ff;
   logic [DSH_W-1:0]      dsh_ff;
   logic [REM_W-1:0]      rem_ff  [NUM_WHEELS];
   logic [PCT_W-1:0]      pct_ff  [NUM_WHEELS];
   omx_dir_type           dir_ff  [NUM_WHEELS];
   logic [DIFF_MAG_W-1:0] dmag_ff [NUM_WHEELS];
   logic                  dneg_ff [NUM_WHEELS];
   logic [PROD_W-1:0]     pm_ff   [NUM_WHEELS];
   logic [QD_W-1:0]       qd_ff   [NUM_WHEELS];
   omx_rsp_type           rsp_ff, rsp_in;

   logic [REM_W-1:0]      rem_init [NUM_WHEELS];
   logic [DIFF_MAG_W-1:0] min_x    [NUM_WHEELS];
   logic [DIFF_MAG_W-1:0] dmag_in  [NUM_WHEELS];
   logic                  dneg_in  [NUM_WHEELS];
   logic                  ge       [NUM_WHEELS];
   logic [RP_W-1:0]       rp       [NUM_WHEELS];
   logic [SUM_W-1:0]      dsum     [NUM_WHEELS];
   logic [DUTY_W-1:0]     duty     [NUM_WHEELS];

   assign rsp_data = rsp_ff;

   always_comb begin
      state_in = state_ff;
      load     = 1'b0;
      rsp_push = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            load = !cmd_empty;
            if (!cmd_empty) state_in = BK_DIV;
         end
         BK_DIV: begin
            if (step_ff == '0) state_in = BK_SCALE;
         end
         BK_SCALE: state_in = BK_RECIP;
         BK_RECIP: state_in = BK_DUTY;
         BK_DUTY:  state_in = BK_EMIT;
         BK_EMIT: begin
            rsp_push = !rsp_full;
            load     = !rsp_full && !cmd_empty;
            if (!rsp_full) state_in = cmd_empty ? BK_IDLE : BK_DIV;
         end
         default: state_in = BK_IDLE;
      endcase
      cmd_pop = load;
   end

   always_comb begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
         // magnitude times 100 as shifts
         rem_init[i] = (REM_W'(cmd_data.mag[i]) << 6) + (REM_W'(cmd_data.mag[i]) << 5)
                     + (REM_W'(cmd_data.mag[i]) << 2);
         min_x[i]    = DIFF_MAG_W'(mins.min_duty[i]);
         dneg_in[i]  = min_x[i] < OFF_DM;
         dmag_in[i]  = dneg_in[i] ? OFF_DM - min_x[i] : min_x[i] - OFF_DM;
         ge[i]       = rem_ff[i] >= REM_W'(dsh_ff);
         // divide by 100 through a scaled reciprocal
         rp[i]       = pm_ff[i] * RECIP_MUL;
         dsum[i]     = dneg_ff[i] ? OFF_SUM - SUM_W'(qd_ff[i]) : OFF_SUM + SUM_W'(qd_ff[i]);
         duty[i]     = dsum[i][DUTY_W-1:0];
      end
      rsp_in.wheel0_duty_a = (dir_ff[0] == DIR_NEG) ? duty[0] : OFF_OUT;
      rsp_in.wheel0_duty_b = (dir_ff[0] == DIR_POS) ? duty[0] : OFF_OUT;
      rsp_in.wheel1_duty_a = (dir_ff[1] == DIR_NEG) ? duty[1] : OFF_OUT;
      rsp_in.wheel1_duty_b = (dir_ff[1] == DIR_POS) ? duty[1] : OFF_OUT;
      rsp_in.wheel2_duty_a = (dir_ff[2] == DIR_NEG) ? duty[2] : OFF_OUT;
      rsp_in.wheel2_duty_b = (dir_ff[2] == DIR_POS) ? duty[2] : OFF_OUT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dsh_ff  <= DSH_W'(cmd_data.divisor) << (PCT_W - 1);
         step_ff <= STEP_W'(PCT_W - 1);
         for (int i = 0; i < NUM_WHEELS; i++) begin
            rem_ff[i]  <= rem_init[i];
            pct_ff[i]  <= '0;
            dir_ff[i]  <= cmd_data.dir[i];
            dmag_ff[i] <= dmag_in[i];
            dneg_ff[i] <= dneg_in[i];
         end
      end else begin
         unique case (state_ff)
            BK_DIV: begin
               dsh_ff  <= dsh_ff >> 1;
               step_ff <= step_ff - 1'b1;
               for (int i = 0; i < NUM_WHEELS; i++) begin
                  if (ge[i]) rem_ff[i] <= rem_ff[i] - REM_W'(dsh_ff);
                  pct_ff[i] <= {pct_ff[i][PCT_W-2:0], ge[i]};
               end
            end
            BK_SCALE: begin
               for (int i = 0; i < NUM_WHEELS; i++) begin
                  pm_ff[i] <= PROD_W'(pct_ff[i]) * PROD_W'(dmag_ff[i]);
               end
            end
            BK_RECIP: begin
               for (int i = 0; i < NUM_WHEELS; i++) begin
                  qd_ff[i] <= rp[i][RECIP_SHIFT +: QD_W];
               end
            end
            BK_DUTY: rsp_ff <= rsp_in;
            default: ;
         endcase
      end
   end

endmodule

[rtl/core/three_wheel_omni_drive_mixer_unit.sv]
// Three-wheel omni drive mixer: velocity command in, six bridge duties out.
// The back end takes a new command only after it has pushed the last result;
// its pace is set by the seven-step percent divider in the back end, whose
// three wheel lanes work in parallel.
// Reset (synchronous, active high) empties both queues, idles the back end and
// clears the three minimum-duty registers to zero.
`timescale 1ns / 1ps

module three_wheel_omni_drive_mixer_unit #(
   parameter int CMD_DEPTH = 2,
   parameter int RSP_DEPTH = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   // command side
   input  logic                                req_push,
   output logic                                req_full,
   input  omx_pkg::omx_req_type                req_data,
   // result side
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output omx_pkg::omx_rsp_type                rsp_data,
   // register writes
   input  logic                                csr_we,
   input  logic [omx_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [omx_pkg::DUTY_W-1:0]          csr_wdata
);
   import omx_pkg::*;

   omx_mins_type mins_ff, mins_in;

   logic        cmd_push, cmd_full, cmd_pop, cmd_empty;
   omx_cmd_type cmd_wr, cmd_rd;
   logic        rsp_push, rsp_full;
   omx_rsp_type rsp_wr;

   // Register file: decode the index, ignore unknown indexes.
   always_comb begin
      mins_in = mins_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WHEEL0_MIN: mins_in.min_duty[0] = csr_wdata;
            CSR_WHEEL1_MIN: mins_in.min_duty[1] = csr_wdata;
            CSR_WHEEL2_MIN: mins_in.min_duty[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mins_ff <= '0;
      end else begin
         mins_ff <= mins_in;
      end
   end

   // Front end: mix, take magnitudes, classify direction, find the divisor.
   omx_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_wr)
   );

   // Decouple the pipelined front from the multi-cycle back end.
   omx_queue #(
      .WIDTH ($bits(omx_cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .full    (cmd_full),
      .wr_data (cmd_wr),
      .pop     (cmd_pop),
      .empty   (cmd_empty),
      .rd_data (cmd_rd)
   );

   // Back end: normalize to a percent and map each wheel to its duty pair.
   omx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mins      (mins_ff),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wr)
   );

   // Hold finished transactions so the back end keeps working while the
   // consumer stalls.
   omx_queue #(
      .WIDTH ($bits(omx_rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .full    (rsp_full),
      .wr_data (rsp_wr),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rsp_data)
   );

   // Back end never writes a result into a full output queue.
   assert property (@(posedge clock) disable iff (reset) rsp_push |-> !rsp_full)
      else $error("result pushed into full queue");

   // Back end takes a command only when one is waiting.
   assert property (@(posedge clock) disable iff (reset) cmd_pop |-> !cmd_empty)
      else $error("command popped from empty queue");

   // Reset leaves both queues empty.
   assert property (@(posedge clock) reset |=> (rsp_empty && cmd_empty))
      else $error("queues not empty after reset");

endmodule

[sim/omx_mixer_checker.sv]
// Checker for the omni drive mixer: watches command, result and register traffic,
// predicts the six bridge duties per command and compares them in order.
// Depends on omx_pkg for the payload structs, widths and register indexes.
`timescale 1ns / 1ps

module omx_mixer_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic                          req_full,
   input  omx_pkg::omx_req_type          req_data,
   input  logic                          rsp_empty,
   input  logic                          rsp_pop,
   input  omx_pkg::omx_rsp_type          rsp_data,
   input  logic                          csr_we,
   input  logic [omx_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [omx_pkg::DUTY_W-1:0]    csr_wdata,
   output int                            fail_count,
   output int                            backlog
);
   import omx_pkg::*;

   localparam int     NUM_FIELDS  = 2 * NUM_WHEELS;
   localparam int     MAX_REPORTS = 20;
   localparam longint OFF_LEVEL   = DUTY_OFF;
   localparam longint INV_SIN60_Q16 = 75674;
   // A wheel speed of exactly one, in units of 2^-29.
   localparam longint FULL_SCALE  = longint'(1) << 29;

   logic [DUTY_W-1:0] min_duty [NUM_WHEELS];
   omx_rsp_type       duty_q [$];
   int                fails = 0;
   int                owed  = 0;
   int                rsp_seq = 0;
   string field_name [NUM_FIELDS] = '{"wheel0_duty_a", "wheel0_duty_b", "wheel1_duty_a",
                                      "wheel1_duty_b", "wheel2_duty_a", "wheel2_duty_b"};

   assign fail_count = fails;
   assign backlog    = owed;

   task automatic flag(input string what);
      if (fails < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
      fails++;
   endtask

   // Mix one velocity command into the six duties, using the current minimums.
   function automatic omx_rsp_type mix_wheels(input omx_req_type cmd);
      longint x, y, w, xs, divisor, pct, duty;
      longint spd [NUM_WHEELS];
      longint amp [NUM_WHEELS];
      logic [DUTY_W-1:0] off_code, drive_code;
      logic [NUM_FIELDS*DUTY_W-1:0] flat;
      x = cmd.vel_x;
      y = cmd.vel_y;
      w = cmd.vel_rot;
      xs = x * INV_SIN60_Q16;
      spd[0] = -xs - y * 32768 - w * 65536;
      spd[1] = y * 65536 - w * 65536;
      spd[2] = xs - y * 32768 - w * 65536;
      divisor = FULL_SCALE;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         amp[i] = (spd[i] < 0) ? -spd[i] : spd[i];
         if (amp[i] > divisor) divisor = amp[i];
      end
      off_code = DUTY_W'(OFF_LEVEL);
      for (int i = 0; i < NUM_WHEELS; i++) begin
         pct = (amp[i] * 100) / divisor;
         // Signed division truncates toward zero, as the mapping requires.
         duty = OFF_LEVEL + (pct * (longint'(min_duty[i]) - OFF_LEVEL)) / 100;
         drive_code = DUTY_W'(duty);
         flat[(NUM_FIELDS - 1 - 2 * i) * DUTY_W +: DUTY_W] = (spd[i] < 0) ? drive_code : off_code;
         flat[(NUM_FIELDS - 2 - 2 * i) * DUTY_W +: DUTY_W] = (spd[i] > 0) ? drive_code : off_code;
      end
      return omx_rsp_type'(flat);
   endfunction

   always @(posedge clock) begin : watch
      omx_rsp_type want;
      logic [NUM_FIELDS*DUTY_W-1:0] got_v, want_v;
      if (reset) begin
         duty_q.delete();
         for (int i = 0; i < NUM_WHEELS; i++) min_duty[i] = '0;
         owed <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_WHEEL0_MIN: min_duty[0] = csr_wdata;
               CSR_WHEEL1_MIN: min_duty[1] = csr_wdata;
               CSR_WHEEL2_MIN: min_duty[2] = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            if (duty_q.size() == 0) begin
               flag($sformatf("result %0d arrived with nothing expected", rsp_seq));
            end else begin
               want   = duty_q.pop_front();
               got_v  = rsp_data;
               want_v = want;
               for (int k = 0; k < NUM_FIELDS; k++) begin
                  if (got_v[(NUM_FIELDS - 1 - k) * DUTY_W +: DUTY_W] !==
                      want_v[(NUM_FIELDS - 1 - k) * DUTY_W +: DUTY_W])
                     flag($sformatf("result %0d %s got %0d want %0d", rsp_seq, field_name[k],
                          got_v[(NUM_FIELDS - 1 - k) * DUTY_W +: DUTY_W],
                          want_v[(NUM_FIELDS - 1 - k) * DUTY_W +: DUTY_W]));
               end
            end
            rsp_seq++;
         end
         if (req_push && !req_full) duty_q.push_back(mix_wheels(req_data));
         owed <= duty_q.size();
      end
   end

endmodule

[sim/three_wheel_omni_drive_mixer_unit_tb.sv]
// Testbench top for the three-wheel omni drive mixer: drives commands, register
// writes and result pops, and gives the verdict from the checker's failure count.
// Depends on omx_pkg, the mixer unit and omx_mixer_checker.
`timescale 1ns / 1ps

module three_wheel_omni_drive_mixer_unit_tb;
   import omx_pkg::*;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int RESET_CYCLES   = 6;
   // Quiet time after the last result has been popped.
   localparam int DRAIN_CYCLES   = 24;
   localparam int RANDOM_PHASES  = 7;
   localparam int CMDS_PER_PHASE = 270;
   localparam int NUM_DIRECTED   = 22;
   // Index that maps to no register; writes to it must leave the minimums alone.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_push  = 1'b0;
   logic              req_full;
   omx_req_type       req_data  = '0;
   logic              rsp_empty;
   logic              rsp_pop   = 1'b0;
   omx_rsp_type       rsp_data;
   logic              csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_WHEEL0_MIN;
   logic [DUTY_W-1:0] csr_wdata = '0;

   int          fail_count;
   int          backlog;
   int unsigned cycle_count  = 0;
   bit          sender_idles = 1'b1;
   int          burst_left   = 0;

   // Hand-picked commands: field extremes, exact unit speed, just past unit
   // speed (normalization), tiny speeds that truncate to zero percent, a
   // wheel at zero speed while the others turn, and mixed signs.
   omx_req_type directed_cmds [NUM_DIRECTED] = '{
      '{16'sd0,     16'sd0,     16'sd0},
      '{16'h7fff,   16'sd0,     16'sd0},
      '{16'h8000,   16'sd0,     16'sd0},
      '{16'sd0,     16'h7fff,   16'sd0},
      '{16'sd0,     16'h8000,   16'sd0},
      '{16'sd0,     16'sd0,     16'h7fff},
      '{16'sd0,     16'sd0,     16'h8000},
      '{16'h7fff,   16'h7fff,   16'h7fff},
      '{16'h8000,   16'h8000,   16'h8000},
      '{16'sd0,     16'sd0,     16'sd8192},
      '{16'sd0,     16'sd0,     -16'sd8192},
      '{16'sd0,     16'sd0,     16'sd8193},
      '{16'sd0,     16'sd0,     16'sd1},
      '{16'sd0,     16'sd0,     -16'sd1},
      '{16'sd4096,  16'sd4096,  16'sd0},
      '{-16'sd7094, 16'sd0,     16'sd0},
      '{16'sd0,     16'sd8192,  16'sd8192},
      '{16'sd100,   -16'sd200,  16'sd300},
      '{16'h7fff,   16'h8000,   16'h7fff},
      '{16'h8000,   16'h7fff,   16'h8000},
      '{16'sd1,     16'sd1,     16'sd1},
      '{16'sd16384, 16'sd0,     16'sd0}
   };

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   three_wheel_omni_drive_mixer_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   omx_mixer_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .backlog    (backlog)
   );

   // Pick one of the interesting field values: the extremes, plus and minus
   // one in Q2.13, zero and the smallest nonzero steps.
   function automatic logic signed [VEL_W-1:0] edge_value();
      case ($urandom_range(0, 6))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'sd0;
         3:       return 16'sd8192;
         4:       return -16'sd8192;
         5:       return 16'sd1;
         default: return -16'sd1;
      endcase
   endfunction

   // Build one random command. Four in ten are fully random; the rest aim at the
   // unnormalized region, single-axis motion, edge values, tiny speeds and
   // a stopped middle wheel (forward speed equal to rotation).
   function automatic omx_req_type random_cmd();
      omx_req_type c;
      c = '0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            c.vel_x   = VEL_W'($urandom);
            c.vel_y   = VEL_W'($urandom);
            c.vel_rot = VEL_W'($urandom);
         end
         4, 5: begin
            c.vel_x   = VEL_W'(int'($urandom_range(0, 24000)) - 12000);
            c.vel_y   = VEL_W'(int'($urandom_range(0, 24000)) - 12000);
            c.vel_rot = VEL_W'(int'($urandom_range(0, 24000)) - 12000);
         end
         6: begin
            case ($urandom_range(0, 2))
               0:       c.vel_x   = VEL_W'($urandom);
               1:       c.vel_y   = VEL_W'($urandom);
               default: c.vel_rot = VEL_W'($urandom);
            endcase
         end
         7: begin
            c.vel_x   = edge_value();
            c.vel_y   = edge_value();
            c.vel_rot = edge_value();
         end
         8: begin
            c.vel_x   = VEL_W'(int'($urandom_range(0, 510)) - 255);
            c.vel_y   = VEL_W'(int'($urandom_range(0, 510)) - 255);
            c.vel_rot = VEL_W'(int'($urandom_range(0, 510)) - 255);
         end
         default: begin
            c.vel_x   = VEL_W'($urandom);
            c.vel_y   = VEL_W'($urandom);
            c.vel_rot = c.vel_y;
         end
      endcase
      return c;
   endfunction

   // Program all three minimums back to back, holding the write enable high
   // across them, and optionally poke the unmapped index too.
   task automatic load_mins(input logic [DUTY_W-1:0] m0, input logic [DUTY_W-1:0] m1,
                            input logic [DUTY_W-1:0] m2, input bit poke_unmapped);
      csr_we    <= 1'b1;
      csr_index <= CSR_WHEEL0_MIN;
      csr_wdata <= m0;
      @(posedge clock);
      csr_index <= CSR_WHEEL1_MIN;
      csr_wdata <= m1;
      @(posedge clock);
      csr_index <= CSR_WHEEL2_MIN;
      csr_wdata <= m2;
      @(posedge clock);
      if (poke_unmapped) begin
         csr_index <= CSR_UNMAPPED;
         csr_wdata <= DUTY_W'($urandom);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Offer one command and hold it until the block takes it. Push stays high
   // inside a burst; a random gap opens before each new burst when idling.
   task automatic send_cmd(input omx_req_type cmd);
      int gap;
      gap = 0;
      if (sender_idles && burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= cmd;
      do @(posedge clock); while (req_full);
   endtask

   // Drop push, wait until every expected result has been popped, then let
   // the pipeline settle before touching the registers again.
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Receiver: the stall pattern follows cycle count bits 9:8, rotating among
   // always ready, coin flip, pop when bits 2:0 are zero, and one-in-five odds.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         case (cycle_count[9:8])
            2'd0:    rsp_pop <= 1'b1;
            2'd1:    rsp_pop <= 1'($urandom_range(0, 1));
            2'd2:    rsp_pop <= (cycle_count[2:0] == 3'd0);
            default: rsp_pop <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int phase;
      int n;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed commands run against the reset minimums (all zero).
      for (n = 0; n < NUM_DIRECTED; n++) send_cmd(directed_cmds[n]);
      drain();

      for (phase = 1; phase <= RANDOM_PHASES; phase++) begin
         case (phase)
            1: load_mins(11'd1024, 11'd1024, 11'd1024, 1'b0);
            // Minimums above off: duty rises with speed.
            2: load_mins(11'd2047, 11'd2047, 11'd2047, 1'b0);
            3: load_mins(11'd0, 11'd1024, 11'd2047, 1'b1);
            4: load_mins(11'd2047, 11'd0, 11'd1024, 1'b0);
            default: load_mins(DUTY_W'($urandom_range(0, 2047)), DUTY_W'($urandom_range(0, 2047)),
                               DUTY_W'($urandom_range(0, 2047)), 1'b1);
         endcase
         // Every third phase streams back to back with no sender gaps.
         sender_idles = (phase % 3) != 0;
         burst_left   = 0;
         for (n = 0; n < CMDS_PER_PHASE; n++) send_cmd(random_cmd());
         drain();
      end

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
